/* design/boot_image_section_parser_defines.svh */
// Assertion macros shared by the boot image section parser RTL.
// Each macro expects clk and arst_n in scope of the including module.
`ifndef BOOT_IMAGE_SECTION_PARSER_DEFINES_SVH
`define BOOT_IMAGE_SECTION_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BISP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define BISP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/bisp_pkg.sv */
// Package for the boot image section parser: payload structs, phase and
// result codes, image format constants. No dependencies.
`timescale 1ns / 1ps

package bisp_pkg;

	localparam int MAX_IMAGE_WORDS = 65536;
	// counters must hold MAX_IMAGE_WORDS itself
	localparam int CNT_W = $clog2(MAX_IMAGE_WORDS + 1);
	localparam logic [31:0] MAX_WORDS_32 = 32'(MAX_IMAGE_WORDS);

	localparam logic [15:0] SIGNATURE  = 16'h5943; // 'C','Y' little-endian
	localparam logic [7:0]  IMAGE_TYPE = 8'hB0;

	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_LENGTH   = 3'd1,
		PH_ADDRESS  = 3'd2,
		PH_DATA     = 3'd3,
		PH_CHECKSUM = 3'd4,
		PH_DONE     = 3'd5,
		PH_HALTED   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_ACCEPT = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_SIGNATURE = 3'd1,
		ERR_NO_CODE   = 3'd2,
		ERR_TYPE      = 3'd3,
		ERR_CHECKSUM  = 3'd4,
		ERR_TOO_LARGE = 3'd5,
		ERR_TRUNCATED = 3'd6
	} err_t;

	typedef struct packed {
		logic [31:0] image_word;
		logic        first_word;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [31:0] target_address;
		logic [31:0] write_data;
		err_t        error_code;
	} out_item_t;

endpackage

/* design/bisp_parse_core.sv */
// Parser state registers and the single-step parse logic.
// Depends on bisp_pkg.
`timescale 1ns / 1ps

module bisp_parse_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  bisp_pkg::in_item_t item,
	output bisp_pkg::out_item_t result
);

	bisp_pkg::phase_t                phase_q, phase_e, phase_d;
	logic [bisp_pkg::CNT_W-1:0]      left_q, left_e, left_d;
	logic [bisp_pkg::CNT_W-1:0]      seen_q, seen_e, seen_d;
	logic [31:0]                     load_q, load_e, load_d;
	logic [31:0]                     sum_q, sum_e, sum_d;
	logic [31:0]                     entry_q, entry_e, entry_d;
	logic [31:0]                     w;
	bisp_pkg::kind_t                 kind;
	bisp_pkg::err_t                  err;
	logic [31:0]                     addr;
	logic [31:0]                     data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bisp_pkg::PH_HEADER;
			left_q  <= '0;
			seen_q  <= '0;
			load_q  <= '0;
			sum_q   <= '0;
			entry_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			seen_q  <= seen_d;
			load_q  <= load_d;
			sum_q   <= sum_d;
			entry_q <= entry_d;
		end
	end

	always_comb begin
		w = item.image_word;
		// first_word restarts from the reset state before this word is parsed
		if (item.first_word) begin
			phase_e = bisp_pkg::PH_HEADER;
			left_e  = '0;
			seen_e  = '0;
			load_e  = '0;
			sum_e   = '0;
			entry_e = '0;
		end else begin
			phase_e = phase_q;
			left_e  = left_q;
			seen_e  = seen_q;
			load_e  = load_q;
			sum_e   = sum_q;
			entry_e = entry_q;
		end

		phase_d = phase_e;
		left_d  = left_e;
		seen_d  = seen_e;
		load_d  = load_e;
		sum_d   = sum_e;
		entry_d = entry_e;
		kind    = bisp_pkg::KIND_NONE;
		err     = bisp_pkg::ERR_NONE;
		addr    = '0;
		data    = '0;

		if (phase_e != bisp_pkg::PH_DONE && phase_e != bisp_pkg::PH_HALTED) begin
			if (seen_e >= bisp_pkg::CNT_W'(bisp_pkg::MAX_IMAGE_WORDS)) begin
				err = bisp_pkg::ERR_TOO_LARGE;
			end else begin
				seen_d = seen_e + 1'b1;
				case (phase_e)
					bisp_pkg::PH_HEADER: begin
						if (w[15:0] != bisp_pkg::SIGNATURE) begin
							err = bisp_pkg::ERR_SIGNATURE;
						end else if (w[16]) begin
							err = bisp_pkg::ERR_NO_CODE;
						end else if (w[31:24] != bisp_pkg::IMAGE_TYPE) begin
							err = bisp_pkg::ERR_TYPE;
						end else begin
							sum_d   = '0;
							phase_d = bisp_pkg::PH_LENGTH;
						end
					end
					bisp_pkg::PH_LENGTH: begin
						if (w > bisp_pkg::MAX_WORDS_32) begin
							err = bisp_pkg::ERR_TOO_LARGE;
						end else begin
							left_d  = w[bisp_pkg::CNT_W-1:0];
							phase_d = bisp_pkg::PH_ADDRESS;
						end
					end
					bisp_pkg::PH_ADDRESS: begin
						// zero-length section: address word is the entry point
						if (left_e == '0) begin
							entry_d = w;
							phase_d = bisp_pkg::PH_CHECKSUM;
						end else begin
							load_d  = w;
							phase_d = bisp_pkg::PH_DATA;
						end
					end
					bisp_pkg::PH_DATA: begin
						kind   = bisp_pkg::KIND_WRITE;
						addr   = load_e;
						data   = w;
						sum_d  = sum_e + w;
						load_d = load_e + 32'd4;
						left_d = left_e - 1'b1;
						if (left_e == bisp_pkg::CNT_W'(1)) begin
							phase_d = bisp_pkg::PH_LENGTH;
						end
					end
					bisp_pkg::PH_CHECKSUM: begin
						if (w == sum_e) begin
							kind    = bisp_pkg::KIND_ACCEPT;
							addr    = entry_e;
							phase_d = bisp_pkg::PH_DONE;
						end else begin
							err = bisp_pkg::ERR_CHECKSUM;
						end
					end
					default: begin
					end
				endcase
			end
			if (err == bisp_pkg::ERR_NONE && item.last_word && phase_d != bisp_pkg::PH_DONE) begin
				err = bisp_pkg::ERR_TRUNCATED;
			end
			if (err != bisp_pkg::ERR_NONE) begin
				kind    = bisp_pkg::KIND_ERROR;
				addr    = '0;
				data    = '0;
				phase_d = bisp_pkg::PH_HALTED;
			end
		end

		result.result_kind    = kind;
		result.target_address = addr;
		result.write_data     = data;
		result.error_code     = err;
	end

endmodule

/* design/boot_image_section_parser.sv */
// Top level of the boot image section parser: input register, parse core,
// result register. Depends on bisp_pkg, bisp_parse_core and the defines header.
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_ready      bisp_pkg::in_item_t
//  result    out        result_valid / result_ready  bisp_pkg::out_item_t
//
// One result per accepted word, held in the input register and then in the result register.
// Sustained rate one word per cycle while result_ready is high: parse state updates as a word moves from
// the input register into the result register.
// item_ready drops only when the input register is full and the result
// register holds a result that is not being taken.
// arst_n clears the parse state (header expected) and both valid flags.
`timescale 1ns / 1ps
`include "boot_image_section_parser_defines.svh"

module boot_image_section_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  bisp_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output bisp_pkg::out_item_t result
);

	logic                valid_s1;
	bisp_pkg::in_item_t  item_s1;
	logic                advance;
	bisp_pkg::out_item_t core_result;
	bisp_pkg::out_item_t result_q;
	logic                result_valid_q;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	bisp_parse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= core_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`BISP_ASSERT_NEXT(a_advance_gives_result, advance, result_valid_q, "advance lost a result")
	`BISP_ASSERT_NOW(a_stall_means_full, !item_ready, valid_s1 && result_valid_q && !result_ready, "item_ready low without a full stall")
	`BISP_ASSERT_NOW(a_error_has_code, result_valid_q && result_q.result_kind == bisp_pkg::KIND_ERROR, result_q.error_code != bisp_pkg::ERR_NONE, "error result without code")
	`BISP_ASSERT_NOW(a_code_only_on_error, result_valid_q && result_q.result_kind != bisp_pkg::KIND_ERROR, result_q.error_code == bisp_pkg::ERR_NONE, "error code on non-error result")

endmodule
